// ===== rtl/core/ted_pkg.sv =====
// Shared types, format codes and the UTF-8 byte check for the text encoding detector.
`default_nettype none

package ted_pkg;

   localparam int FMT_W = 3;
   localparam int CONT_W = 3;

   // Format codes, shared by the result port and the running verdict.
   localparam logic [FMT_W-1:0] FMT_EMPTY  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_ANSI   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_UTF8   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_UCS2LE = 3'd3;
   localparam logic [FMT_W-1:0] FMT_UCS2BE = 3'd4;

   // Mark lengths.
   localparam logic [1:0] MARK_NONE  = 2'd0;
   localparam logic [1:0] MARK_UCS2  = 2'd2;
   localparam logic [1:0] MARK_UTF8  = 2'd3;

   // Byte values of interest.
   localparam logic [7:0] BYTE_TERM = 8'h00;
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_FE   = 8'hFE;
   localparam logic [7:0] BYTE_EF   = 8'hEF;
   localparam logic [7:0] BYTE_BB   = 8'hBB;
   localparam logic [7:0] BYTE_BF   = 8'hBF;

   typedef enum logic [2:0] {
      PH_START,
      PH_HOLD1,
      PH_HOLD2,
      PH_MARKED,
      PH_SCAN
   } phase_type;

   typedef struct packed {
      logic [FMT_W-1:0]  verdict;
      logic [CONT_W-1:0] cont;
   } scan_type;

   // One step of the UTF-8 lead and continuation check.
   function automatic scan_type check_byte(input scan_type s, input logic [7:0] b);
      scan_type r;
      r = s;
      if (s.verdict == FMT_ANSI) begin
         r = s;
      end else if (s.cont != '0) begin
         if (b[7:6] == 2'b10) begin
            r.cont = s.cont - 3'd1;
         end else begin
            r.verdict = FMT_ANSI;
            r.cont = '0;
         end
      end else if (b[7] == 1'b0) begin
         r = s;
      end else if (b < 8'hC0 || b > 8'hFD) begin
         r.verdict = FMT_ANSI;
      end else if (b < 8'hE0) begin
         r.cont = 3'd1;
      end else if (b < 8'hF0) begin
         r.cont = 3'd2;
      end else if (b < 8'hF8) begin
         r.cont = 3'd3;
      end else if (b < 8'hFC) begin
         r.cont = 3'd4;
      end else begin
         r.cont = 3'd5;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_encoding_detector.sv =====
// Top level of the text encoding detector: byte order mark and UTF-8 validity scan.
//
// Path: a terminator byte passes through one input register, then one result
// register, and its result shows on the rsp_ port from the result register.
// Throughput: one byte per cycle; only a terminator waits, and only while the
// previous result still sits unaccepted in the result register.
// Reset: synchronous, active high; clears the scan state and both valid flags.
`default_nettype none

module text_encoding_detector (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ted_pkg::FMT_W-1:0]      rsp_text_format,
   output logic [1:0]                     rsp_mark_length
);
   import ted_pkg::*;

   // Input register stage.
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;

   // Running scan state for the current string.
   phase_type        phase_ff, phase_in;
   logic [15:0]      held_ff, held_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [CONT_W-1:0] cont_ff, cont_in;
   logic [FMT_W-1:0] verdict_ff, verdict_in;
   logic             payload_ff, payload_in;
   logic [1:0]       mark_len_ff, mark_len_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FMT_W-1:0] rsp_fmt_ff, rsp_fmt_in;
   logic [1:0]       rsp_mark_ff, rsp_mark_in;

   logic             is_term;
   logic             advance;
   logic             term_adv;
   scan_type         cur_scan;
   scan_type         replay_hi;
   scan_type         replayed;
   scan_type         checked;
   logic [7:0]       held_lo;

   // The byte in the input register moves on every cycle, unless it is a
   // terminator and the result register still holds an unaccepted result.
   assign is_term  = (in_byte_ff == BYTE_TERM);
   assign advance  = in_valid_ff && (!is_term || !rsp_valid_ff || rsp_ready);
   assign term_adv = advance && is_term;
   assign req_ready = !in_valid_ff || advance;

   assign held_lo = held_ff[7:0];

   // Held candidate mark bytes that turn out not to be a mark are checked
   // in order, older byte first, ahead of the current byte.
   always_comb begin
      cur_scan.verdict = verdict_ff;
      cur_scan.cont    = cont_ff;
      replay_hi = cur_scan;
      if (held_cnt_ff >= 2'd2) begin
         replay_hi = check_byte(cur_scan, held_ff[15:8]);
      end
      replayed = replay_hi;
      if (held_cnt_ff >= 2'd1) begin
         replayed = check_byte(replay_hi, held_lo);
      end
      checked = check_byte(replayed, in_byte_ff);
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Next scan state and result.
   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      cont_in     = cont_ff;
      verdict_in  = verdict_ff;
      payload_in  = payload_ff;
      mark_len_in = mark_len_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_fmt_in   = rsp_fmt_ff;
      rsp_mark_in  = rsp_mark_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         if (is_term) begin
            // The terminator closes the string and always produces a result.
            rsp_valid_in = 1'b1;
            rsp_mark_in  = mark_len_ff;
            case (phase_ff)
               PH_START: begin
                  rsp_fmt_in = FMT_EMPTY;
               end
               PH_MARKED: begin
                  rsp_fmt_in = payload_ff ? verdict_ff : FMT_EMPTY;
               end
               default: begin
                  // A sequence cut short by the terminator is not valid UTF-8.
                  if (replayed.verdict == FMT_ANSI || replayed.cont != '0) begin
                     rsp_fmt_in = FMT_ANSI;
                  end else if (replayed.verdict == FMT_EMPTY) begin
                     rsp_fmt_in = FMT_UTF8;
                  end else begin
                     rsp_fmt_in = replayed.verdict;
                  end
               end
            endcase
            phase_in    = PH_START;
            held_in     = '0;
            held_cnt_in = '0;
            cont_in     = '0;
            verdict_in  = FMT_EMPTY;
            payload_in  = 1'b0;
            mark_len_in = MARK_NONE;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (in_byte_ff == BYTE_FF || in_byte_ff == BYTE_FE ||
                      in_byte_ff == BYTE_EF) begin
                     held_in     = {8'h00, in_byte_ff};
                     held_cnt_in = 2'd1;
                     phase_in    = PH_HOLD1;
                  end else begin
                     verdict_in = checked.verdict;
                     cont_in    = checked.cont;
                     payload_in = 1'b1;
                     phase_in   = PH_SCAN;
                  end
               end
               PH_HOLD1: begin
                  if (held_lo == BYTE_FF && in_byte_ff == BYTE_FE) begin
                     verdict_in  = FMT_UCS2LE;
                     mark_len_in = MARK_UCS2;
                     held_in     = '0;
                     held_cnt_in = '0;
                     phase_in    = PH_MARKED;
                  end else if (held_lo == BYTE_FE && in_byte_ff == BYTE_FF) begin
                     verdict_in  = FMT_UCS2BE;
                     mark_len_in = MARK_UCS2;
                     held_in     = '0;
                     held_cnt_in = '0;
                     phase_in    = PH_MARKED;
                  end else if (held_lo == BYTE_EF && in_byte_ff == BYTE_BB) begin
                     held_in     = {held_lo, in_byte_ff};
                     held_cnt_in = 2'd2;
                     phase_in    = PH_HOLD2;
                  end else begin
                     verdict_in  = checked.verdict;
                     cont_in     = checked.cont;
                     held_in     = '0;
                     held_cnt_in = '0;
                     payload_in  = 1'b1;
                     phase_in    = PH_SCAN;
                  end
               end
               PH_HOLD2: begin
                  if (in_byte_ff == BYTE_BF) begin
                     verdict_in  = FMT_UTF8;
                     mark_len_in = MARK_UTF8;
                     held_in     = '0;
                     held_cnt_in = '0;
                     phase_in    = PH_MARKED;
                  end else begin
                     verdict_in  = checked.verdict;
                     cont_in     = checked.cont;
                     held_in     = '0;
                     held_cnt_in = '0;
                     payload_in  = 1'b1;
                     phase_in    = PH_SCAN;
                  end
               end
               PH_MARKED: begin
                  // After a mark the payload is not checked, only noted.
                  payload_in = 1'b1;
               end
               default: begin
                  verdict_in = checked.verdict;
                  cont_in    = checked.cont;
                  payload_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         held_ff      <= '0;
         held_cnt_ff  <= '0;
         cont_ff      <= '0;
         verdict_ff   <= FMT_EMPTY;
         payload_ff   <= 1'b0;
         mark_len_ff  <= MARK_NONE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         held_cnt_ff  <= held_cnt_in;
         cont_ff      <= cont_in;
         verdict_ff   <= verdict_in;
         payload_ff   <= payload_in;
         mark_len_ff  <= mark_len_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_fmt_ff <= rsp_fmt_in;
      rsp_mark_ff <= rsp_mark_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_format = rsp_fmt_ff;
   assign rsp_mark_length = rsp_mark_ff;

   // A new result appears only after a terminator has been consumed.
   a_result_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(term_adv))
      else $error("result appeared without a terminator");

   // A two-byte mark can only report empty or a UCS-2 format.
   a_ucs2_mark_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mark_ff == MARK_UCS2) |->
      (rsp_fmt_ff == FMT_EMPTY || rsp_fmt_ff == FMT_UCS2LE || rsp_fmt_ff == FMT_UCS2BE))
      else $error("two-byte mark with a wrong format");

   // A three-byte mark can only report empty or UTF-8.
   a_utf8_mark_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mark_ff == MARK_UTF8) |->
      (rsp_fmt_ff == FMT_EMPTY || rsp_fmt_ff == FMT_UTF8))
      else $error("three-byte mark with a wrong format");

   // Pending continuation bytes exist only during a plain scan that has not failed.
   a_cont_in_scan: assert property (@(posedge clock) disable iff (reset)
      (cont_ff != '0) |-> (phase_ff == PH_SCAN && verdict_ff != FMT_ANSI))
      else $error("continuation count outside a live scan");

   // Held mark bytes match the hold phase.
   a_held_count: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_HOLD1) == (held_cnt_ff == 2'd1)) &&
      ((phase_ff == PH_HOLD2) == (held_cnt_ff == 2'd2)))
      else $error("held byte count does not match the phase");

endmodule

`default_nettype wire
